// ===== hdl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, codes and character helpers for the directive token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned KindWidth  = 4;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned OpWidth    = 2;
   localparam int unsigned MaxResults = 4;
   localparam int unsigned SlotWidth  = $clog2(MaxResults);
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   // Input opcodes
   localparam logic [OpWidth-1:0] OP_CODE_POINT = 2'd0;
   localparam logic [OpWidth-1:0] OP_END        = 2'd1;
   localparam logic [OpWidth-1:0] OP_RESTART    = 2'd2;
   localparam logic [OpWidth-1:0] OP_RESERVED   = 2'd3;

   // Token kinds
   localparam logic [KindWidth-1:0] KIND_TEXT   = 4'd0;
   localparam logic [KindWidth-1:0] KIND_AT     = 4'd1;
   localparam logic [KindWidth-1:0] KIND_LPAREN = 4'd2;
   localparam logic [KindWidth-1:0] KIND_RPAREN = 4'd3;
   localparam logic [KindWidth-1:0] KIND_LCURLY = 4'd4;
   localparam logic [KindWidth-1:0] KIND_RCURLY = 4'd5;
   localparam logic [KindWidth-1:0] KIND_COMMA  = 4'd6;
   localparam logic [KindWidth-1:0] KIND_NAME   = 4'd7;
   localparam logic [KindWidth-1:0] KIND_STRING = 4'd8;
   localparam logic [KindWidth-1:0] KIND_END    = 4'd9;
   localparam logic [KindWidth-1:0] KIND_ERROR  = 4'd10;

   // Characters
   localparam logic [CpWidth-1:0] CH_AT         = 21'h40;
   localparam logic [CpWidth-1:0] CH_LPAREN     = 21'h28;
   localparam logic [CpWidth-1:0] CH_RPAREN     = 21'h29;
   localparam logic [CpWidth-1:0] CH_LCURLY     = 21'h7B;
   localparam logic [CpWidth-1:0] CH_RCURLY     = 21'h7D;
   localparam logic [CpWidth-1:0] CH_COMMA      = 21'h2C;
   localparam logic [CpWidth-1:0] CH_QUOTE      = 21'h22;
   localparam logic [CpWidth-1:0] CH_UNDERSCORE = 21'h5F;
   localparam logic [CpWidth-1:0] CH_BACKSLASH  = 21'h5C;
   localparam logic [CpWidth-1:0] CP_MAX        = 21'h10FFFF;
   localparam logic [CpWidth-1:0] SURR_LO       = 21'h00D800;
   localparam logic [CpWidth-1:0] SURR_HI       = 21'h00DFFF;

   typedef enum logic [5:0] {
      MODE_IDLE = 6'b000001,
      MODE_NAME = 6'b000010,
      MODE_STR  = 6'b000100,
      MODE_ESC  = 6'b001000,
      MODE_ERR  = 6'b010000,
      MODE_END  = 6'b100000
   } mode_type;

   // What one item produces: up to four results and the mode it leaves behind
   typedef struct packed {
      logic [CountWidth-1:0]                 count;
      logic [MaxResults-1:0][KindWidth-1:0]  kind;
      logic [MaxResults-1:0][ByteWidth-1:0]  tbyte;
      mode_type                              next_mode;
   } plan_type;

   function automatic logic is_letter(input logic [CpWidth-1:0] c);
      return ((c >= 21'h41) && (c <= 21'h5A)) || ((c >= 21'h61) && (c <= 21'h7A));
   endfunction

   function automatic logic is_name_start(input logic [CpWidth-1:0] c);
      return is_letter(c) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_name_char(input logic [CpWidth-1:0] c);
      return is_name_start(c) || ((c >= 21'h30) && (c <= 21'h39));
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dts_if.sv =====
// ----------------------------------------------------------------------------
// dts channels
// Valid/ready channels for scanner input items and result tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface dts_req_if;
   logic                              valid;
   logic                              ready;
   logic [dts_pkg::OpWidth-1:0]       opcode;
   logic [dts_pkg::CpWidth-1:0]       code_point;

   modport source (output valid, output opcode, output code_point, input ready);
   modport sink   (input valid, input opcode, input code_point, output ready);
endinterface

interface dts_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dts_pkg::KindWidth-1:0]     token_kind;
   logic [dts_pkg::ByteWidth-1:0]     text_byte;
   logic                              last;

   modport source (output valid, output token_kind, output text_byte, output last,
                   input ready);
   modport sink   (input valid, input token_kind, input text_byte, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/dts_decode.sv =====
// ----------------------------------------------------------------------------
// dts_decode
// Classify one held item against the scan mode and plan its results.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_decode (
   input  wire logic [dts_pkg::OpWidth-1:0]  opcode,
   input  wire logic [dts_pkg::CpWidth-1:0]  code_point,
   input  dts_pkg::mode_type                 mode,
   output dts_pkg::plan_type                 plan
);

   logic                             st_has;
   logic [dts_pkg::KindWidth-1:0]    st_kind;
   logic [dts_pkg::ByteWidth-1:0]    st_byte;
   dts_pkg::mode_type                st_mode;

   logic [dts_pkg::CountWidth-1:0]                      u_len;
   logic [dts_pkg::MaxResults-1:0][dts_pkg::ByteWidth-1:0] u_byte;

   logic cp_bad;

   // Start of a new token from idle
   always_comb begin
      st_has  = 1'b1;
      st_byte = '0;
      st_mode = dts_pkg::MODE_IDLE;
      st_kind = dts_pkg::KIND_ERROR;
      case (code_point)
         dts_pkg::CH_AT:     st_kind = dts_pkg::KIND_AT;
         dts_pkg::CH_LPAREN: st_kind = dts_pkg::KIND_LPAREN;
         dts_pkg::CH_RPAREN: st_kind = dts_pkg::KIND_RPAREN;
         dts_pkg::CH_LCURLY: st_kind = dts_pkg::KIND_LCURLY;
         dts_pkg::CH_RCURLY: st_kind = dts_pkg::KIND_RCURLY;
         dts_pkg::CH_COMMA:  st_kind = dts_pkg::KIND_COMMA;
         dts_pkg::CH_QUOTE: begin
            st_has  = 1'b0;
            st_kind = dts_pkg::KIND_TEXT;
            st_mode = dts_pkg::MODE_STR;
         end
         default: begin
            if (dts_pkg::is_name_start(code_point)) begin
               st_kind = dts_pkg::KIND_TEXT;
               st_byte = code_point[7:0];
               st_mode = dts_pkg::MODE_NAME;
            end else begin
               st_kind = dts_pkg::KIND_ERROR;
               st_mode = dts_pkg::MODE_ERR;
            end
         end
      endcase
   end

   // UTF-8 encoding of the code point
   always_comb begin
      u_byte = '0;
      if (code_point < 21'h80) begin
         u_len     = 3'd1;
         u_byte[0] = code_point[7:0];
      end else if (code_point < 21'h800) begin
         u_len     = 3'd2;
         u_byte[0] = {3'b110, code_point[10:6]};
         u_byte[1] = {2'b10, code_point[5:0]};
      end else if (code_point < 21'h10000) begin
         u_len     = 3'd3;
         u_byte[0] = {4'b1110, code_point[15:12]};
         u_byte[1] = {2'b10, code_point[11:6]};
         u_byte[2] = {2'b10, code_point[5:0]};
      end else begin
         u_len     = 3'd4;
         u_byte[0] = {5'b11110, code_point[20:18]};
         u_byte[1] = {2'b10, code_point[17:12]};
         u_byte[2] = {2'b10, code_point[11:6]};
         u_byte[3] = {2'b10, code_point[5:0]};
      end
   end

   assign cp_bad = (code_point > dts_pkg::CP_MAX) ||
                   ((code_point >= dts_pkg::SURR_LO) && (code_point <= dts_pkg::SURR_HI));

   always_comb begin
      plan           = '0;
      plan.next_mode = mode;
      if (opcode == dts_pkg::OP_RESTART) begin
         plan.next_mode = dts_pkg::MODE_IDLE;
      end else if (opcode == dts_pkg::OP_RESERVED) begin
         plan.next_mode = mode;
      end else if (mode == dts_pkg::MODE_ERR) begin
         plan.count   = 3'd1;
         plan.kind[0] = dts_pkg::KIND_ERROR;
      end else if (mode == dts_pkg::MODE_END) begin
         plan.count   = 3'd1;
         plan.kind[0] = dts_pkg::KIND_END;
      end else if (opcode == dts_pkg::OP_END) begin
         case (mode)
            dts_pkg::MODE_STR, dts_pkg::MODE_ESC: begin
               plan.count     = 3'd1;
               plan.kind[0]   = dts_pkg::KIND_ERROR;
               plan.next_mode = dts_pkg::MODE_ERR;
            end
            dts_pkg::MODE_NAME: begin
               plan.count     = 3'd2;
               plan.kind[0]   = dts_pkg::KIND_NAME;
               plan.kind[1]   = dts_pkg::KIND_END;
               plan.next_mode = dts_pkg::MODE_END;
            end
            default: begin
               plan.count     = 3'd1;
               plan.kind[0]   = dts_pkg::KIND_END;
               plan.next_mode = dts_pkg::MODE_END;
            end
         endcase
      end else begin
         case (mode)
            dts_pkg::MODE_NAME: begin
               if (dts_pkg::is_name_char(code_point)) begin
                  plan.count    = 3'd1;
                  plan.kind[0]  = dts_pkg::KIND_TEXT;
                  plan.tbyte[0] = code_point[7:0];
               end else begin
                  // close the name, then rescan this character
                  plan.kind[0]   = dts_pkg::KIND_NAME;
                  plan.kind[1]   = st_kind;
                  plan.tbyte[1]  = st_byte;
                  plan.count     = st_has ? 3'd2 : 3'd1;
                  plan.next_mode = st_mode;
               end
            end
            dts_pkg::MODE_STR: begin
               if (code_point == dts_pkg::CH_QUOTE) begin
                  plan.count     = 3'd1;
                  plan.kind[0]   = dts_pkg::KIND_STRING;
                  plan.next_mode = dts_pkg::MODE_IDLE;
               end else if (code_point == dts_pkg::CH_BACKSLASH) begin
                  plan.next_mode = dts_pkg::MODE_ESC;
               end else if (cp_bad) begin
                  plan.count     = 3'd1;
                  plan.kind[0]   = dts_pkg::KIND_ERROR;
                  plan.next_mode = dts_pkg::MODE_ERR;
               end else begin
                  plan.count = u_len;
                  plan.tbyte = u_byte;
               end
            end
            dts_pkg::MODE_ESC: begin
               plan.count = 3'd1;
               if ((code_point == dts_pkg::CH_BACKSLASH) ||
                   (code_point == dts_pkg::CH_QUOTE)) begin
                  plan.kind[0]   = dts_pkg::KIND_TEXT;
                  plan.tbyte[0]  = code_point[7:0];
                  plan.next_mode = dts_pkg::MODE_STR;
               end else begin
                  plan.kind[0]   = dts_pkg::KIND_ERROR;
                  plan.next_mode = dts_pkg::MODE_ERR;
               end
            end
            default: begin
               plan.count     = st_has ? 3'd1 : 3'd0;
               plan.kind[0]   = st_kind;
               plan.tbyte[0]  = st_byte;
               plan.next_mode = st_mode;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dts_serializer.sv =====
// ----------------------------------------------------------------------------
// dts_serializer
// Step through the planned results of the held item into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_serializer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  dts_pkg::plan_type                  plan,
   output logic                               item_done,
   input  wire logic                          out_ready,
   output logic                               out_valid,
   output logic [dts_pkg::KindWidth-1:0]      out_kind,
   output logic [dts_pkg::ByteWidth-1:0]      out_byte,
   output logic                               out_last
);

   logic                               valid_ff, valid_in;
   logic [dts_pkg::SlotWidth-1:0]      idx_ff, idx_in;
   logic [dts_pkg::KindWidth-1:0]      kind_ff;
   logic [dts_pkg::ByteWidth-1:0]      byte_ff;
   logic                               last_ff;

   logic out_free, has_results, last_slot, load;

   assign out_free    = !valid_ff || out_ready;
   assign has_results = (plan.count != '0);
   assign last_slot   = (({1'b0, idx_ff} + 3'd1) == plan.count);
   assign load        = item_valid && has_results && out_free;
   assign item_done   = item_valid && (!has_results || (out_free && last_slot));

   assign valid_in = load || (valid_ff && !out_ready);
   assign idx_in   = load ? (last_slot ? '0 : idx_ff + 2'd1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= plan.kind[idx_ff];
         byte_ff <= plan.tbyte[idx_ff];
         last_ff <= last_slot;
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

// ===== hdl/directive_token_scanner_core.sv =====
// ----------------------------------------------------------------------------
// directive_token_scanner_core
// Stream scanner for directive text: punctuation, names and quoted strings.
// ----------------------------------------------------------------------------
// Each input transfer carries a code point, an end-of-input mark or a restart.
// The core emits one result transfer per token: @ ( ) { } and comma, the
// UTF-8 bytes of name and string text followed by a closing name or string
// token, an end token, or an error token. Errors are sticky until a restart;
// after end of input every item but a reserved opcode answers with an end
// token until a restart. The last result caused by an input item carries
// last = 1. Items that cause no result (restart, reserved opcode, opening
// quote, backslash in a string) never wait on the result channel. Throughput
// is one item per cycle while each item causes at most one result and no
// result stalls; an item causing several results (a name closed by anything
// but a quote, or a code point of two to four UTF-8 bytes) holds the input
// while the single result register drains them one per cycle. Results are
// registered after the input register. While a result waits, an item with
// results stays in the input register and holds off further input transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module directive_token_scanner_core (
   input  wire logic   clock,
   input  wire logic   reset,
   dts_req_if.sink     req_bus,
   dts_rsp_if.source   rsp_bus
);

   // Input register: one item held while its results are produced
   logic                              item_valid_ff, item_valid_in;
   logic [dts_pkg::OpWidth-1:0]       opcode_ff;
   logic [dts_pkg::CpWidth-1:0]       code_point_ff;

   // Scan mode, advanced when the held item retires
   dts_pkg::mode_type                 mode_ff, mode_in;

   dts_pkg::plan_type                 plan;
   logic                              item_done;
   logic                              req_accept;

   // Take a new item when the register is empty or its item retires now
   assign req_bus.ready = !item_valid_ff || item_done;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign item_valid_in = req_accept || (item_valid_ff && !item_done);
   assign mode_in       = item_done ? plan.next_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         mode_ff       <= dts_pkg::MODE_IDLE;
      end else begin
         item_valid_ff <= item_valid_in;
         mode_ff       <= mode_in;
      end
   end

   // Hold the payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_accept) begin
         opcode_ff     <= req_bus.opcode;
         code_point_ff <= req_bus.code_point;
      end
   end

   // Decode the held item against the current mode
   dts_decode u_decode (
      .opcode     (opcode_ff),
      .code_point (code_point_ff),
      .mode       (mode_ff),
      .plan       (plan)
   );

   // Drain the planned results into the result register, one per cycle unless stalled
   dts_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .plan       (plan),
      .item_done  (item_done),
      .out_ready  (rsp_bus.ready),
      .out_valid  (rsp_bus.valid),
      .out_kind   (rsp_bus.token_kind),
      .out_byte   (rsp_bus.text_byte),
      .out_last   (rsp_bus.last)
   );

endmodule

`default_nettype wire

// ===== hdl/dts_checker.sv =====
// ----------------------------------------------------------------------------
// dts_checker
// Port-level checks on the scanner result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [dts_pkg::KindWidth-1:0] rsp_token_kind,
   input  wire logic [dts_pkg::ByteWidth-1:0] rsp_text_byte,
   input  wire logic                          rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_text_byte) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= dts_pkg::KIND_ERROR)
      else $error("token kind out of range");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind != dts_pkg::KIND_TEXT) |-> rsp_text_byte == '0)
      else $error("text byte set on a non-text token");

   // Error and end tokens always close the results of their item
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_token_kind == dts_pkg::KIND_ERROR) ||
                    (rsp_token_kind == dts_pkg::KIND_END)) |-> rsp_last)
      else $error("error or end token not marked last");

endmodule

bind directive_token_scanner_core dts_checker u_dts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_token_kind (rsp_bus.token_kind),
   .rsp_text_byte  (rsp_bus.text_byte),
   .rsp_last       (rsp_bus.last)
);

`default_nettype wire

// ===== tb/sv/directive_token_scanner_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directive_token_scanner_core_test
// Self-checking bench for the directive token scanner. A short stimulus table
// covers the punctuation tokens, the UTF-8 length steps, escapes and the sticky
// error and end modes. Random directive text, broken strings and noise follow.
// Every result transfer is checked against the table rows or a scanner model in the bench.
// ----------------------------------------------------------------------------
module directive_token_scanner_core_test;

   localparam int unsigned HalfPeriod   = 6;       // 12 ns clock
   localparam int unsigned ResetCycles  = 4;
   localparam int unsigned RandomItems  = 420;
   localparam int unsigned SettleCycles = 8;       // settle time after the expected tokens drain
   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned DrainLimit   = 20000;
   localparam int unsigned PauseAtItem  = 120;     // sender drains the scanner here
   localparam int unsigned HoldAtItem   = 230;     // receiver holds off here
   localparam int unsigned HoldCycles   = 160;
   localparam int          Predicted    = -1;

   typedef logic [dts_pkg::CpWidth-1:0]   cp_type;
   typedef logic [dts_pkg::OpWidth-1:0]   op_type;
   typedef logic [dts_pkg::KindWidth-1:0] kind_type;

   // One result transfer as the scanner should present it
   typedef struct packed {
      logic [dts_pkg::KindWidth-1:0] kind;
      logic [dts_pkg::ByteWidth-1:0] tbyte;
      logic                          last;
   } token_type;

   // One row of the stimulus table; typed rows carry up to two token kinds
   // (text byte zero), other rows take their tokens from the scanner model
   typedef struct {
      op_type   op;
      cp_type   cp;
      int       typed;
      kind_type kind_a;
      kind_type kind_b;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dts_req_if req_ch ();
   dts_rsp_if rsp_ch ();

   directive_token_scanner_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   dts_pkg::mode_type scan_state;
   token_type   expected_tokens[$];
   row_type     directed_rows[$];
   int unsigned errors         = 0;
   int unsigned cycles         = 0;
   int unsigned accepted_items = 0;
   int unsigned random_items   = 0;
   int unsigned tokens_seen    = 0;
   bit          steady         = 1'b0;   // no idling on either side while set

   cp_type punct_cps [6] = '{dts_pkg::CH_AT, dts_pkg::CH_LPAREN, dts_pkg::CH_RPAREN,
                             dts_pkg::CH_LCURLY, dts_pkg::CH_RCURLY, dts_pkg::CH_COMMA};
   // UTF-8 length steps and the code points around the surrogate block
   cp_type boundary_cps [10] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800,
                                 21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000,
                                 dts_pkg::CP_MAX};

   always #(HalfPeriod) clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Scanner model
   // ------------------------------------------------------------------------
   function automatic logic starts_name(input cp_type c);
      // A-Z, a-z or underscore
      return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)
             || c == dts_pkg::CH_UNDERSCORE;
   endfunction

   function automatic logic continues_name(input cp_type c);
      return starts_name(c) || (c >= 21'h30 && c <= 21'h39);
   endfunction

   function automatic void emit_token(input kind_type k,
                                      input logic [dts_pkg::ByteWidth-1:0] b);
      expected_tokens.push_back('{kind: k, tbyte: b, last: 1'b0});
   endfunction

   function automatic void emit_utf8(input cp_type c);
      if (c < 21'h80) begin
         emit_token(dts_pkg::KIND_TEXT, c[7:0]);
      end else if (c < 21'h800) begin
         emit_token(dts_pkg::KIND_TEXT, {3'b110, c[10:6]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[5:0]});
      end else if (c < 21'h10000) begin
         emit_token(dts_pkg::KIND_TEXT, {4'b1110, c[15:12]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[11:6]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[5:0]});
      end else begin
         emit_token(dts_pkg::KIND_TEXT, {5'b11110, c[20:18]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[17:12]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[11:6]});
         emit_token(dts_pkg::KIND_TEXT, {2'b10, c[5:0]});
      end
   endfunction

   // Scan a code point between tokens
   function automatic void open_token(input cp_type c);
      scan_state = dts_pkg::MODE_IDLE;
      case (c)
         dts_pkg::CH_AT:     emit_token(dts_pkg::KIND_AT, 8'h00);
         dts_pkg::CH_LPAREN: emit_token(dts_pkg::KIND_LPAREN, 8'h00);
         dts_pkg::CH_RPAREN: emit_token(dts_pkg::KIND_RPAREN, 8'h00);
         dts_pkg::CH_LCURLY: emit_token(dts_pkg::KIND_LCURLY, 8'h00);
         dts_pkg::CH_RCURLY: emit_token(dts_pkg::KIND_RCURLY, 8'h00);
         dts_pkg::CH_COMMA:  emit_token(dts_pkg::KIND_COMMA, 8'h00);
         dts_pkg::CH_QUOTE:  scan_state = dts_pkg::MODE_STR;   // opening quote is silent
         default: begin
            if (starts_name(c)) begin
               scan_state = dts_pkg::MODE_NAME;
               emit_token(dts_pkg::KIND_TEXT, c[7:0]);
            end else begin
               scan_state = dts_pkg::MODE_ERR;
               emit_token(dts_pkg::KIND_ERROR, 8'h00);
            end
         end
      endcase
   endfunction

   // Advance the model by one accepted item and queue the tokens it causes
   function automatic void scan_item(input op_type op, input cp_type c);
      int        base;
      token_type tail;
      base = expected_tokens.size();
      if (op == dts_pkg::OP_RESTART) begin
         scan_state = dts_pkg::MODE_IDLE;
      end else if (op != dts_pkg::OP_RESERVED) begin
         if (scan_state == dts_pkg::MODE_ERR) begin
            emit_token(dts_pkg::KIND_ERROR, 8'h00);
         end else if (scan_state == dts_pkg::MODE_END) begin
            emit_token(dts_pkg::KIND_END, 8'h00);
         end else if (op == dts_pkg::OP_END) begin
            if (scan_state == dts_pkg::MODE_STR || scan_state == dts_pkg::MODE_ESC) begin
               scan_state = dts_pkg::MODE_ERR;
               emit_token(dts_pkg::KIND_ERROR, 8'h00);
            end else begin
               // close an open name before the end token
               if (scan_state == dts_pkg::MODE_NAME) emit_token(dts_pkg::KIND_NAME, 8'h00);
               scan_state = dts_pkg::MODE_END;
               emit_token(dts_pkg::KIND_END, 8'h00);
            end
         end else if (scan_state == dts_pkg::MODE_NAME) begin
            if (continues_name(c)) begin
               emit_token(dts_pkg::KIND_TEXT, c[7:0]);
            end else begin
               // close the name, then rescan the code point as a new token
               emit_token(dts_pkg::KIND_NAME, 8'h00);
               open_token(c);
            end
         end else if (scan_state == dts_pkg::MODE_STR) begin
            if (c == dts_pkg::CH_QUOTE) begin
               scan_state = dts_pkg::MODE_IDLE;
               emit_token(dts_pkg::KIND_STRING, 8'h00);
            end else if (c == dts_pkg::CH_BACKSLASH) begin
               scan_state = dts_pkg::MODE_ESC;
            end else if (c > dts_pkg::CP_MAX ||
                         (c >= dts_pkg::SURR_LO && c <= dts_pkg::SURR_HI)) begin
               scan_state = dts_pkg::MODE_ERR;
               emit_token(dts_pkg::KIND_ERROR, 8'h00);
            end else begin
               emit_utf8(c);
            end
         end else if (scan_state == dts_pkg::MODE_ESC) begin
            if (c == dts_pkg::CH_BACKSLASH || c == dts_pkg::CH_QUOTE) begin
               scan_state = dts_pkg::MODE_STR;
               emit_token(dts_pkg::KIND_TEXT, c[7:0]);
            end else begin
               scan_state = dts_pkg::MODE_ERR;
               emit_token(dts_pkg::KIND_ERROR, 8'h00);
            end
         end else begin
            open_token(c);
         end
      end
      // mark the final token of this item
      if (expected_tokens.size() > base) begin
         tail = expected_tokens.pop_back();
         tail.last = 1'b1;
         expected_tokens.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Mostly back-to-back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic cp_type any_cp();
      return cp_type'($urandom);
   endfunction

   function automatic cp_type pick_name_cp(input bit first);
      int unsigned r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return cp_type'(32'h41 + r);        // upper case
      if (r < 52) return cp_type'(32'h61 + r - 26);   // lower case
      if (r == 52) return dts_pkg::CH_UNDERSCORE;
      return cp_type'(32'h30 + r - 53);               // digit
   endfunction

   // Legal string text; quote and backslash are left to the escape path
   function automatic cp_type pick_text_cp();
      cp_type c;
      case ($urandom_range(0, 5))
         0, 1: begin
            c = cp_type'($urandom_range(21'h20, 21'h7E));
            if (c == dts_pkg::CH_QUOTE || c == dts_pkg::CH_BACKSLASH) c = 21'h41;
         end
         2: c = cp_type'($urandom_range(21'h80, 21'h7FF));
         3: begin
            c = cp_type'($urandom_range(21'h800, 21'hFFFF));
            if (c >= dts_pkg::SURR_LO && c <= dts_pkg::SURR_HI) c = 21'hE000;
         end
         4: c = cp_type'($urandom_range(21'h10000, dts_pkg::CP_MAX));
         default: c = boundary_cps[$urandom_range(0, 9)];
      endcase
      return c;
   endfunction

   function automatic void add_row(input op_type op, input cp_type cp,
                                   input int typed, input kind_type ka,
                                   input kind_type kb);
      row_type row;
      row.op     = op;
      row.cp     = cp;
      row.typed  = typed;
      row.kind_a = ka;
      row.kind_b = kb;
      directed_rows.push_back(row);
   endfunction

   // Offer one item, wait for the transfer and queue what it should produce.
   // Valid stays high after the transfer; the next call or a drain decides.
   task automatic send_row(input row_type row);
      int unsigned gap;
      int          base;
      token_type   dropped;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= row.op;
      req_ch.code_point <= row.cp;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      base = expected_tokens.size();
      scan_item(row.op, row.cp);
      if (row.typed != Predicted) begin
         // keep the mode update, take the tokens from the table instead
         while (expected_tokens.size() > base) dropped = expected_tokens.pop_back();
         if (row.typed >= 1)
            expected_tokens.push_back('{kind: row.kind_a, tbyte: 8'h00,
                                        last: row.typed == 1});
         if (row.typed == 2)
            expected_tokens.push_back('{kind: row.kind_b, tbyte: 8'h00, last: 1'b1});
      end
      accepted_items++;
   endtask

   task automatic send_item(input op_type op, input cp_type cp);
      row_type row;
      row.op     = op;
      row.cp     = cp;
      row.typed  = Predicted;
      row.kind_a = dts_pkg::KIND_TEXT;
      row.kind_b = dts_pkg::KIND_TEXT;
      send_row(row);
      random_items++;
   endtask

   // Drop valid and wait until every queued token has come out
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One token of directive text: punctuation, a name or a quoted string
   task automatic send_token();
      int unsigned n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: send_item(dts_pkg::OP_CODE_POINT, punct_cps[$urandom_range(0, 5)]);
         4, 5, 6: begin
            send_item(dts_pkg::OP_CODE_POINT, pick_name_cp(1'b1));
            n = $urandom_range(0, 6);
            repeat (n) send_item(dts_pkg::OP_CODE_POINT, pick_name_cp(1'b0));
         end
         default: begin
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0) begin
                  send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_BACKSLASH);
                  send_item(dts_pkg::OP_CODE_POINT,
                            $urandom_range(0, 1) ? dts_pkg::CH_QUOTE : dts_pkg::CH_BACKSLASH);
               end else begin
                  send_item(dts_pkg::OP_CODE_POINT, pick_text_cp());
               end
            end
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
         end
      endcase
   endtask

   // Well-formed text from a fresh start, usually closed by end of input
   task automatic send_directive();
      steady = ($urandom_range(0, 3) == 0);
      send_item(dts_pkg::OP_RESTART, any_cp());
      repeat ($urandom_range(1, 8)) send_token();
      if ($urandom_range(0, 3) != 0) begin
         send_item(dts_pkg::OP_END, any_cp());
         // poke the ended mode now and then
         if ($urandom_range(0, 2) == 0) send_item(dts_pkg::OP_CODE_POINT, any_cp());
      end
   endtask

   // Bad escapes, unterminated or illegal strings, and raw noise
   task automatic send_broken();
      cp_type c;
      steady = 1'b0;
      send_item(dts_pkg::OP_RESTART, any_cp());
      case ($urandom_range(0, 4))
         0: begin
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 3)) send_item(dts_pkg::OP_CODE_POINT, pick_text_cp());
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_BACKSLASH);
            c = pick_text_cp();
            send_item(dts_pkg::OP_CODE_POINT, c);
         end
         1: begin
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 3)) send_item(dts_pkg::OP_CODE_POINT, pick_text_cp());
            send_item(dts_pkg::OP_END, any_cp());
         end
         2: begin
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
            send_item(dts_pkg::OP_CODE_POINT,
                      cp_type'($urandom_range(dts_pkg::SURR_LO, dts_pkg::SURR_HI)));
         end
         3: begin
            send_item(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE);
            send_item(dts_pkg::OP_CODE_POINT,
                      cp_type'($urandom_range(dts_pkg::CP_MAX + 1, 21'h1FFFFF)));
         end
         default: begin
            repeat ($urandom_range(1, 6)) send_item(op_type'($urandom_range(0, 3)), any_cp());
         end
      endcase
      // sticky error answers
      repeat ($urandom_range(0, 2)) send_item(dts_pkg::OP_CODE_POINT, any_cp());
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, and one long hold-off that fills the scanner
   // ------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      bit          held;
      stall = 0;
      held  = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && random_items >= HoldAtItem) begin
            held  = 1'b1;
            stall = HoldCycles;
         end
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare every result transfer with the oldest queued token
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: token_kind %0d text_byte 0x%02h last %0b",
                   rsp_ch.token_kind, rsp_ch.text_byte, rsp_ch.last);
            errors++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_ch.token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_ch.token_kind);
               errors++;
            end
            if (rsp_ch.text_byte !== want.tbyte) begin
               $error("text_byte: expected 0x%02h, got 0x%02h", want.tbyte, rsp_ch.text_byte);
               errors++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender and run control
   // ------------------------------------------------------------------------
   initial begin
      bit paused;
      paused = 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= dts_pkg::OP_CODE_POINT;
      req_ch.code_point <= '0;
      scan_state = dts_pkg::MODE_IDLE;

      // punctuation straight after reset
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_RPAREN, 1,
              dts_pkg::KIND_RPAREN, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_AT,     1,
              dts_pkg::KIND_AT,     dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_LPAREN, 1,
              dts_pkg::KIND_LPAREN, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_LCURLY, 1,
              dts_pkg::KIND_LCURLY, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_RCURLY, 1,
              dts_pkg::KIND_RCURLY, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_COMMA,  1,
              dts_pkg::KIND_COMMA,  dts_pkg::KIND_TEXT);
      // name Z_ closed by an opening quote
      add_row(dts_pkg::OP_CODE_POINT, 21'h5A,                 Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_UNDERSCORE, Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE,      Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      // four, two and three byte text, an escaped quote, then the closing quote
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CP_MAX,       Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, 21'h7FF,               Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, 21'hFFFF,              Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_BACKSLASH, Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE,     Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE,     Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      // name closed by a comma: two results from one item
      add_row(dts_pkg::OP_CODE_POINT, 21'h61,            Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_COMMA, 2,
              dts_pkg::KIND_NAME, dts_pkg::KIND_COMMA);
      // reserved opcode is ignored; top code point is illegal; error is sticky
      add_row(dts_pkg::OP_RESERVED,   21'h1FFFFF, 0, dts_pkg::KIND_TEXT,  dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_CODE_POINT, 21'h1FFFFF, 1, dts_pkg::KIND_ERROR, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_END,        21'h0,      1, dts_pkg::KIND_ERROR, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_RESTART,    21'h1FFFFF, 0, dts_pkg::KIND_TEXT,  dts_pkg::KIND_TEXT);
      // end inside a name, then the ended mode
      add_row(dts_pkg::OP_CODE_POINT, 21'h71, Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_END,        21'h0,  2, dts_pkg::KIND_NAME, dts_pkg::KIND_END);
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_AT, 1,
              dts_pkg::KIND_END, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_RESTART,    21'h0,  0, dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      // end inside a string
      add_row(dts_pkg::OP_CODE_POINT, dts_pkg::CH_QUOTE, Predicted,
              dts_pkg::KIND_TEXT, dts_pkg::KIND_TEXT);
      add_row(dts_pkg::OP_END,        21'h0, 1, dts_pkg::KIND_ERROR, dts_pkg::KIND_TEXT);

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_row(directed_rows[i]);
      wait_drained();
      random_items = 0;

      // random part; pause once until the scanner is empty
      while (random_items < RandomItems) begin
         if ($urandom_range(0, 4) == 0) send_broken();
         else send_directive();
         if (!paused && random_items >= PauseAtItem) begin
            paused = 1'b1;
            wait_drained();
         end
      end
      steady = 1'b0;

      // hold valid low, let the remaining tokens drain, then settle
      req_ch.valid <= 1'b0;
      for (int k = 0; k < DrainLimit && expected_tokens.size() != 0; k++) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", expected_tokens.size());
         errors += expected_tokens.size();
      end

      $display("Scanned %0d items (%0d directed, %0d random), checked %0d tokens.",
               accepted_items, directed_rows.size(), random_items, tokens_seen);
      $display("Random text mixed names, strings, escapes and broken input, with a long stall.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
